>>> rtl/barc_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and fixed-point constants for the barometer
// compensation core. No dependencies.
package barc_pkg;

	typedef logic signed [31:0] word_t;

	localparam int NUM_REGS   = 5;
	localparam int REG_IDX_W  = 3;
	localparam int NUM_STAGES = 16;
	localparam int IN_W       = 48;
	localparam int OUT_W      = 64;

	localparam logic [REG_IDX_W-1:0] REG_CALIB_01 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CALIB_23 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CALIB_45 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CALIB_67 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CALIB_89 = 3'd4;

	localparam word_t RAW_OFFSET = 32'sd8388608;
	localparam word_t C1_OFS     = 32'sd4459;
	localparam word_t C2_OFS     = 32'sd256;
	localparam word_t T_BASE     = 32'sd81920000;
	localparam word_t C5_OFS     = 32'sd4443;
	localparam word_t C4_OFS     = 32'sd120586;
	localparam word_t C8_OFS     = 32'sd7180;
	localparam word_t C7_OFS     = 32'sd166426;
	localparam word_t CF_BASE    = 32'sd2097152;
	localparam word_t P_OFS      = 32'sd99880;

	typedef struct packed {
		word_t c1k;
		word_t c2k;
		word_t c3;
		word_t c4k;
		word_t c5k;
		word_t c6;
		word_t k7;
		word_t c8k;
		word_t c9;
		word_t c10;
		word_t c11;
		word_t c12;
	} coef_t;

endpackage

>>> rtl/barometer_raw_compensation_core.sv
`timescale 1ns / 1ps
// Barometer raw compensation core, top level. Uses barc_pkg, barc_coef, barc_ctl,
// barc_temp and barc_pres.
// Pipeline: 16 register stages; m_tvalid rises once a pair reaches the last stage.
// At most one multiplier level per stage.
// Throughput: one pair per cycle unless full and stalled; bubbles collapse on a stall.
// Reset: clears the calibration registers and all stage valid bits.
module barometer_raw_compensation_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [barc_pkg::IN_W-1:0]      s_tdata,   // raw_pressure, raw_temperature
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [barc_pkg::OUT_W-1:0]     m_tdata,   // temperature_centideg, pressure_pascal
	input  logic                           cfg_we,
	input  logic [barc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_wdata
);
	import barc_pkg::*;

	logic [NUM_STAGES:1] en;
	word_t               c0sh;
	coef_t               coef;
	logic [23:0]         up_s5;
	word_t               rt_s5, dt2_s5, rt_s16, rp_s16;

	barc_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.c0sh      (c0sh),
		.coef      (coef)
	);

	barc_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.en       (en)
	);

	barc_temp u_temp (
		.clk             (clk),
		.en              (en),
		.raw_pressure    (s_tdata[23:0]),
		.raw_temperature (s_tdata[47:24]),
		.c0sh            (c0sh),
		.coef            (coef),
		.up_s5           (up_s5),
		.rt_s5           (rt_s5),
		.dt2_s5          (dt2_s5)
	);

	barc_pres u_pres (
		.clk    (clk),
		.en     (en),
		.coef   (coef),
		.up_s5  (up_s5),
		.rt_s5  (rt_s5),
		.dt2_s5 (dt2_s5),
		.rt_s16 (rt_s16),
		.rp_s16 (rp_s16)
	);

	assign m_tdata = {rp_s16, rt_s16};

endmodule

>>> rtl/barc_coef.sv
`timescale 1ns / 1ps
// Calibration register file and coefficient unpacking.
// Depends on barc_pkg.
module barc_coef (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [barc_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_wdata,
	output barc_pkg::word_t                  c0sh,
	output barc_pkg::coef_t                  coef
);
	import barc_pkg::*;

	logic [31:0] calib_q [NUM_REGS];
	logic [15:0] r0, r1, r2, r3, r4, r5, r6, r7, r8, r9;
	coef_t       coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) calib_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CALIB_01: calib_q[0] <= cfg_wdata;
				REG_CALIB_23: calib_q[1] <= cfg_wdata;
				REG_CALIB_45: calib_q[2] <= cfg_wdata;
				REG_CALIB_67: calib_q[3] <= cfg_wdata;
				REG_CALIB_89: calib_q[4] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign r0 = calib_q[0][31:16];
	assign r1 = calib_q[0][15:0];
	assign r2 = calib_q[1][31:16];
	assign r3 = calib_q[1][15:0];
	assign r4 = calib_q[2][31:16];
	assign r5 = calib_q[2][15:0];
	assign r6 = calib_q[3][31:16];
	assign r7 = calib_q[3][15:0];
	assign r8 = calib_q[4][31:16];
	assign r9 = calib_q[4][15:0];

	assign c0sh = $signed({16'd0, r0[15:4], 4'd0});

	always_ff @(posedge clk) begin
		coef_q.c1k <= $signed({21'd0, r1[15:8], r2[2:0]}) + C1_OFS;
		coef_q.c2k <= $signed({23'd0, r1[7:0], r4[0]}) - C2_OFS;
		coef_q.c3  <= $signed({19'd0, r2[15:3]});
		coef_q.c4k <= ($signed({14'd0, r3, r0[1:0]}) + C4_OFS) <<< 4;
		coef_q.c5k <= $signed({17'd0, r4[15:1]}) - C5_OFS;
		coef_q.c6  <= $signed({19'd0, r5[15:3]});
		coef_q.k7  <= $signed({13'd0, r6, r5[2:0]}) + C7_OFS;
		coef_q.c8k <= $signed({19'd0, r7[15:3]}) + C8_OFS;
		coef_q.c9  <= $signed({18'd0, r8[15:2]});
		coef_q.c10 <= $signed({22'd0, r9[15:8], r8[1:0]});
		coef_q.c11 <= $signed({24'd0, r9[7:0]});
		coef_q.c12 <= $signed({27'd0, r0[3:2], r7[2:0]});
	end

	assign coef = coef_q;

endmodule

>>> rtl/barc_ctl.sv
`timescale 1ns / 1ps
// Pipeline valid bits and per-stage advance enables with bubble collapsing.
// Depends on barc_pkg.
module barc_ctl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [barc_pkg::NUM_STAGES:1]     en
);
	import barc_pkg::*;

	logic [NUM_STAGES:1] v_q;
	logic [NUM_STAGES:0] vin;

	always_comb begin
		en[NUM_STAGES] = !v_q[NUM_STAGES] || m_tready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign vin = {v_q, s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (en[k]) v_q[k] <= vin[k-1];
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = v_q[NUM_STAGES];

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&v_q))
		else $error("input blocked while pipeline has a bubble");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(v_q) == $past($countones(v_q))
			+ int'($past(s_tvalid && s_tready)) - int'($past(m_tvalid && m_tready))))
		else $error("item count in pipeline lost or duplicated");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[NUM_STAGES-1] && !en[NUM_STAGES-1]) |=> v_q[NUM_STAGES-1])
		else $error("stalled stage dropped its item");

endmodule

>>> rtl/barc_temp.sv
`timescale 1ns / 1ps
// Temperature path, stages 1 to 5: offset removal, cubic polynomial, rt and dt2.
// Depends on barc_pkg.
module barc_temp (
	input  logic                           clk,
	input  logic [barc_pkg::NUM_STAGES:1]  en,
	input  logic [23:0]                    raw_pressure,
	input  logic [23:0]                    raw_temperature,
	input  barc_pkg::word_t                c0sh,
	input  barc_pkg::coef_t                coef,
	output logic [23:0]                    up_s5,
	output barc_pkg::word_t                rt_s5,
	output barc_pkg::word_t                dt2_s5
);
	import barc_pkg::*;

	logic [23:0] up_s1, up_s2, up_s3, up_s4;
	word_t dt_s1, dt_s2, dt_s3;
	word_t x01_s2, a_s2, b_s2;
	word_t x01_s3, x02_s3, b2_s3;
	word_t x03_s4, sum12_s4;
	word_t dt_n, p01, pa, pb, pa2, pb2, p03, tsum;

	assign dt_n = (($signed({8'd0, raw_temperature}) - RAW_OFFSET) >>> 4) + c0sh;
	assign p01  = coef.c1k * dt_s1;
	assign pa   = coef.c2k * dt_s1;
	assign pb   = coef.c3 * dt_s1;
	assign pa2  = a_s2 * dt_s2;
	assign pb2  = b_s2 * dt_s2;
	assign p03  = b2_s3 * dt_s3;
	assign tsum = sum12_s4 + x03_s4;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dt_s1 <= dt_n;
			up_s1 <= raw_pressure;
		end
		if (en[2]) begin
			x01_s2 <= p01 >>> 1;
			a_s2   <= pa >>> 14;
			b_s2   <= pb >>> 18;
			dt_s2  <= dt_s1;
			up_s2  <= up_s1;
		end
		if (en[3]) begin
			x02_s3 <= pa2 >>> 4;
			b2_s3  <= pb2 >>> 18;
			x01_s3 <= x01_s2;
			dt_s3  <= dt_s2;
			up_s3  <= up_s2;
		end
		if (en[4]) begin
			x03_s4   <= p03;
			sum12_s4 <= x01_s3 + x02_s3;
			up_s4    <= up_s3;
		end
		if (en[5]) begin
			rt_s5  <= (T_BASE - tsum) >>> 15;
			dt2_s5 <= tsum >>> 12;
			up_s5  <= up_s4;
		end
	end

endmodule

>>> rtl/barc_pres.sv
`timescale 1ns / 1ps
// Pressure path, stages 6 to 16: offset, gain, second-order correction.
// Depends on barc_pkg.
module barc_pres (
	input  logic                           clk,
	input  logic [barc_pkg::NUM_STAGES:1]  en,
	input  barc_pkg::coef_t                coef,
	input  logic [23:0]                    up_s5,
	input  barc_pkg::word_t                rt_s5,
	input  barc_pkg::word_t                dt2_s5,
	output barc_pkg::word_t                rt_s16,
	output barc_pkg::word_t                rp_s16
);
	import barc_pkg::*;

	logic [23:0] up_s6, up_s7, up_s8;
	word_t rt_s6, rt_s7, rt_s8, rt_s9, rt_s10, rt_s11, rt_s12, rt_s13, rt_s14, rt_s15;
	word_t dt2_s6;
	word_t x11_s6, e_s6, x21_s6, f_s6, cfm_s6;
	word_t x11_s7, x12_s7, x21_s7, x22_s7, cf_s7;
	word_t x13_s8, x23_s8, g_s8, h0_s8;
	logic  ge_s8, ge_s9;
	word_t x24_s9, x25_s9, pp1_s9, g_s9, h0_s9;
	word_t xs_s10, pp1_s10, g_s10, h0_s10;
	word_t x26_s11, pp1_s11, g_s11, h0_s11;
	word_t pp2_s12, pp3_s12, g_s12, h0_s12;
	word_t pp4_s13, g_s13, h0_s13;
	word_t x31_s14, h_s14, pp4_s14;
	word_t x31_s15, x32_s15, pp4_s15;

	word_t p11, pe, p21, pf, pcf, p12, p22, pg, ph0, p24, p25, p2, p3, p31, ph, p32;

	assign p11 = coef.c5k * dt2_s5;
	assign pe  = coef.c6 * dt2_s5;
	assign p21 = coef.c8k * dt2_s5;
	assign pf  = coef.c9 * dt2_s5;
	assign pcf = coef.c12 * dt2_s5;
	assign p12 = e_s6 * dt2_s6;
	assign p22 = f_s6 * dt2_s6;
	assign pg  = cf_s7 * coef.c10;
	assign ph0 = cf_s7 * coef.c11;
	assign p24 = (x23_s8 >>> 11) * coef.k7;
	assign p25 = $signed({21'd0, x23_s8[10:0]}) * coef.k7;
	assign p2  = (x26_s11 >>> 11) * pp1_s11;
	assign p3  = $signed({21'd0, x26_s11[10:0]}) * pp1_s11;
	assign p31 = g_s13 * pp4_s13;
	assign ph  = h0_s13 * pp4_s13;
	assign p32 = h_s14 * pp4_s14;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			x11_s6 <= p11;
			e_s6   <= pe >>> 16;
			x21_s6 <= p21 >>> 10;
			f_s6   <= pf >>> 17;
			cfm_s6 <= pcf;
			dt2_s6 <= dt2_s5;
			up_s6  <= up_s5;
			rt_s6  <= rt_s5;
		end
		if (en[7]) begin
			x12_s7 <= p12 >>> 2;
			x22_s7 <= p22 >>> 12;
			cf_s7  <= (CF_BASE + cfm_s6) >>> 3;
			x11_s7 <= x11_s6;
			x21_s7 <= x21_s6;
			up_s7  <= up_s6;
			rt_s7  <= rt_s6;
		end
		if (en[8]) begin
			x13_s8 <= ((x11_s7 + x12_s7) >>> 10) + coef.c4k;
			ge_s8  <= x21_s7 >= x22_s7;
			x23_s8 <= (x21_s7 >= x22_s7) ? (x21_s7 - x22_s7) : (x22_s7 - x21_s7);
			g_s8   <= pg >>> 17;
			h0_s8  <= ph0 >>> 15;
			up_s8  <= up_s7;
			rt_s8  <= rt_s7;
		end
		if (en[9]) begin
			x24_s9 <= p24;
			x25_s9 <= p25 >>> 11;
			pp1_s9 <= (($signed({8'd0, up_s8}) - RAW_OFFSET) - x13_s8) >>> 3;
			ge_s9  <= ge_s8;
			g_s9   <= g_s8;
			h0_s9  <= h0_s8;
			rt_s9  <= rt_s8;
		end
		if (en[10]) begin
			xs_s10  <= ge_s9 ? (-x24_s9 - x25_s9) : (x24_s9 + x25_s9);
			pp1_s10 <= pp1_s9;
			g_s10   <= g_s9;
			h0_s10  <= h0_s9;
			rt_s10  <= rt_s9;
		end
		if (en[11]) begin
			x26_s11 <= (xs_s10 >>> 11) + coef.k7;
			pp1_s11 <= pp1_s10;
			g_s11   <= g_s10;
			h0_s11  <= h0_s10;
			rt_s11  <= rt_s10;
		end
		if (en[12]) begin
			pp2_s12 <= p2;
			pp3_s12 <= p3 >>> 11;
			g_s12   <= g_s11;
			h0_s12  <= h0_s11;
			rt_s12  <= rt_s11;
		end
		if (en[13]) begin
			pp4_s13 <= (pp2_s12 + pp3_s12) >>> 10;
			g_s13   <= g_s12;
			h0_s13  <= h0_s12;
			rt_s13  <= rt_s12;
		end
		if (en[14]) begin
			x31_s14 <= p31 >>> 2;
			h_s14   <= ph >>> 18;
			pp4_s14 <= pp4_s13;
			rt_s14  <= rt_s13;
		end
		if (en[15]) begin
			x32_s15 <= p32;
			x31_s15 <= x31_s14;
			pp4_s15 <= pp4_s14;
			rt_s15  <= rt_s14;
		end
		if (en[16]) begin
			rp_s16 <= ((x31_s15 + x32_s15) >>> 15) + pp4_s15 + P_OFS;
			rt_s16 <= rt_s15;
		end
	end

endmodule

>>> tb/sv/barometer_raw_compensation_checker.sv
`timescale 1ns / 1ps
// Checker for barometer_raw_compensation_core: watches the input, output and calibration
// write ports and predicts each compensated reading; compares whole readings. Uses barc_pkg.
module barometer_raw_compensation_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [barc_pkg::IN_W-1:0]      s_tdata,   // raw_pressure, raw_temperature
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [barc_pkg::OUT_W-1:0]     m_tdata,   // temperature_centideg, pressure_pascal
	input  logic                           cfg_we,
	input  logic [barc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_wdata,
	output int                             errors,
	output int                             pending
);
	import barc_pkg::*;

	typedef struct packed {
		word_t pressure_pascal;
		word_t temperature_centideg;
	} reading_t;

	localparam word_t FRAC_MASK = 32'sh7FF;

	logic [31:0] calib_words [NUM_REGS];
	reading_t    awaited_readings [$];

	function automatic reading_t compensate(input logic [23:0] raw_p, input logic [23:0] raw_t);
		logic [15:0] r [10];
		word_t c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12;
		word_t up, ut, dt, x01, x02, x03, dt2;
		word_t x11, x12, x13, x21, x22, x23, k7, x24, x25, x26;
		word_t pp1, pp2, pp3, pp4, cf, x31, x32;
		reading_t res;
		for (int k = 0; k < 10; k++)
			r[k] = k[0] ? calib_words[k >> 1][15:0] : calib_words[k >> 1][31:16];
		c0  = 32'(r[0][15:4]);
		c1  = 32'({r[1][15:8], r[2][2:0]});
		c2  = 32'({r[1][7:0], r[4][0]});
		c3  = 32'(r[2][15:3]);
		c4  = 32'({r[3], r[0][1:0]});
		c5  = 32'(r[4][15:1]);
		c6  = 32'(r[5][15:3]);
		c7  = 32'({r[6], r[5][2:0]});
		c8  = 32'(r[7][15:3]);
		c9  = 32'(r[8][15:2]);
		c10 = 32'({r[9][15:8], r[8][1:0]});
		c11 = 32'(r[9][7:0]);
		c12 = 32'({r[0][3:2], r[7][2:0]});
		up  = 32'(raw_p);
		ut  = 32'(raw_t);

		dt  = ((ut - RAW_OFFSET) >>> 4) + (c0 <<< 4);
		x01 = ((c1 + C1_OFS) * dt) >>> 1;
		x02 = ((((c2 - C2_OFS) * dt) >>> 14) * dt) >>> 4;
		x03 = ((((c3 * dt) >>> 18) * dt) >>> 18) * dt;
		res.temperature_centideg = (T_BASE - x01 - x02 - x03) >>> 15;
		dt2 = (x01 + x02 + x03) >>> 12;

		x11 = (c5 - C5_OFS) * dt2;
		x12 = (((c6 * dt2) >>> 16) * dt2) >>> 2;
		x13 = ((x11 + x12) >>> 10) + ((c4 + C4_OFS) <<< 4);

		x21 = ((c8 + C8_OFS) * dt2) >>> 10;
		x22 = (((c9 * dt2) >>> 17) * dt2) >>> 12;
		x23 = (x22 >= x21) ? (x22 - x21) : (x21 - x22);
		k7  = c7 + C7_OFS;
		x24 = (x23 >>> 11) * k7;
		x25 = ((x23 & FRAC_MASK) * k7) >>> 11;
		if (x21 >= x22)
			x26 = ((-x24 - x25) >>> 11) + k7;
		else
			x26 = ((x24 + x25) >>> 11) + k7;

		pp1 = ((up - RAW_OFFSET) - x13) >>> 3;
		pp2 = (x26 >>> 11) * pp1;
		pp3 = ((x26 & FRAC_MASK) * pp1) >>> 11;
		pp4 = (pp2 + pp3) >>> 10;

		cf  = (CF_BASE + c12 * dt2) >>> 3;
		x31 = ((((cf * c10) >>> 17) * pp4) >>> 2);
		x32 = (((((cf * c11) >>> 15) * pp4) >>> 18) * pp4);
		res.pressure_pascal = ((x31 + x32) >>> 15) + pp4 + P_OFS;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t exp_r, got_r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				calib_words[i] = '0;
			awaited_readings.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r = m_tdata;
				if (awaited_readings.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result temp %0d pres %0d", $time,
							got_r.temperature_centideg, got_r.pressure_pascal);
					errors <= errors + 1;
				end else begin
					exp_r = awaited_readings.pop_front();
					if (got_r !== exp_r) begin
						if (errors < 10)
							$display("%0t: mismatch temp exp %0d got %0d, pres exp %0d got %0d",
								$time, exp_r.temperature_centideg, got_r.temperature_centideg,
								exp_r.pressure_pascal, got_r.pressure_pascal);
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				awaited_readings.push_back(compensate(s_tdata[23:0], s_tdata[47:24]));
			if (cfg_we && cfg_index < NUM_REGS)
				calib_words[cfg_index] = cfg_wdata;
			pending <= awaited_readings.size();
		end
	end

endmodule

>>> tb/sv/barometer_raw_compensation_core_test.sv
`timescale 1ns / 1ps
// Testbench top for barometer_raw_compensation_core: drives raw reading pairs and
// calibration writes, stalls both sides at random. Uses barc_pkg and the checker module.
module barometer_raw_compensation_core_test;
	import barc_pkg::*;

	typedef enum {CAL_ZERO, CAL_ONES, CAL_TYPICAL, CAL_RANDOM} calib_style_t;

	localparam logic [REG_IDX_W-1:0] CALIB_REGS [NUM_REGS] =
		'{REG_CALIB_01, REG_CALIB_23, REG_CALIB_45, REG_CALIB_67, REG_CALIB_89};
	localparam logic [31:0] TYPICAL_WORDS [NUM_REGS] =
		'{32'hA1B2_3C4D, 32'h5E6F_7081, 32'h92A3_B4C5, 32'hD6E7_F809, 32'h1A2B_3C4D};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;    // raw_pressure, raw_temperature
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;         // temperature_centideg, pressure_pascal
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_wdata = '0;
	logic                 gap_free = 1'b0;
	int                   errors;
	int                   pending;

	barometer_raw_compensation_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	barometer_raw_compensation_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	always @(negedge clk)
		m_tready = gap_free || ($urandom_range(0, 99) >= 21);

	task automatic send_reading(input logic [23:0] raw_p, input logic [23:0] raw_t);
		@(negedge clk);
		while (!gap_free && $urandom_range(0, 99) < 21) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {raw_t, raw_p};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic program_calib(input calib_style_t style);
		logic [31:0] val;
		drain();
		for (int i = 0; i < NUM_REGS; i++) begin
			case (style)
				CAL_ZERO:    val = '0;
				CAL_ONES:    val = '1;
				CAL_TYPICAL: val = TYPICAL_WORDS[i];
				default:     val = $urandom;
			endcase
			write_reg(CALIB_REGS[i], val);
		end
		// out-of-range index, must be dropped
		write_reg(REG_IDX_W'(NUM_REGS + $urandom_range(0, 2)), $urandom);
	endtask

	task automatic send_directed();
		send_reading(24'h000000, 24'h000000);
		send_reading(24'hFFFFFF, 24'hFFFFFF);
		send_reading(24'h000000, 24'hFFFFFF);
		send_reading(24'hFFFFFF, 24'h000000);
		send_reading(24'h800000, 24'h800000);
		send_reading(24'h7FFFFF, 24'h800001);
	endtask

	task automatic send_random();
		logic [23:0] raw_p, raw_t;
		if ($urandom_range(0, 1)) begin
			raw_p = 24'($urandom);
			raw_t = 24'($urandom);
		end else begin
			raw_p = 24'(7340032 + $urandom_range(0, 2097152));
			raw_t = 24'(7340032 + $urandom_range(0, 2097152));
		end
		send_reading(raw_p, raw_t);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_directed();
		program_calib(CAL_ONES);
		send_directed();
		program_calib(CAL_TYPICAL);
		send_directed();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				2:       program_calib(CAL_ZERO);
				4:       program_calib(CAL_ONES);
				default: program_calib(CAL_RANDOM);
			endcase
			gap_free = (phase == 3);
			repeat (310) send_random();
		end
		gap_free = 1'b0;

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
